@@ rtl/core/fqd_pkg.sv @@
package fqd_pkg;

  localparam int DEPTH_DEFAULT = 16;

  localparam int CMD_W       = 3;
  localparam int VALUE_W     = 32;
  localparam int STATUS_W    = 3;
  localparam int COUNT_OUT_W = 5;

  typedef logic [CMD_W-1:0]       cmd_t;
  typedef logic [VALUE_W-1:0]     value_t;
  typedef logic [STATUS_W-1:0]    status_t;
  typedef logic [COUNT_OUT_W-1:0] count_out_t;

  localparam cmd_t CMD_ENQUEUE = 3'd0;
  localparam cmd_t CMD_DEQUEUE = 3'd1;
  localparam cmd_t CMD_DELETE  = 3'd2;
  localparam cmd_t CMD_LENGTH  = 3'd3;
  localparam cmd_t CMD_ITERATE = 3'd4;

  localparam status_t ST_OK       = 3'd0;
  localparam status_t ST_ZERO     = 3'd1;
  localparam status_t ST_EMPTY    = 3'd2;
  localparam status_t ST_NOTFOUND = 3'd3;
  localparam status_t ST_FULL     = 3'd4;

endpackage

@@ rtl/core/fqd_ram.sv @@
module fqd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data holds until the next read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/fifo_queue_with_delete.sv @@
// Bounded FIFO of non-zero 32-bit handles, DEPTH entries deep, held in a single-port-read
// RAM. Commands are taken one at a time; cmd_stall stays high until the last result of the
// current command has been loaded into the output register. Delete reads the entries in turn
// up to the match, then moves each later entry up one place; iterate reads every entry and
// gives one result per entry, or a single result when the queue is empty. All reads share
// the one RAM read port with its registered read, and every write and every read but the
// dequeue read of the head go through the shared head-plus-offset address unit. A stalled
// result output holds the command in its emit state. The store needs no clearing after
// reset.
module fifo_queue_with_delete #(
  parameter int DEPTH = fqd_pkg::DEPTH_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_valid,
  output logic                 cmd_stall,
  input  fqd_pkg::cmd_t        command,
  input  fqd_pkg::value_t      item_value,
  output logic                 res_valid,
  input  logic                 res_stall,
  output fqd_pkg::status_t     status,
  output fqd_pkg::value_t      value_out,
  output fqd_pkg::count_out_t  count_out,
  output logic                 last
);

  import fqd_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CMD   = 4'd1;
  localparam logic [3:0] S_DHEAD = 4'd2;
  localparam logic [3:0] S_SRD   = 4'd3;
  localparam logic [3:0] S_SCMP  = 4'd4;
  localparam logic [3:0] S_SHRD  = 4'd5;
  localparam logic [3:0] S_SHWR  = 4'd6;
  localparam logic [3:0] S_IRD   = 4'd7;
  localparam logic [3:0] S_EMIT  = 4'd8;

  logic [3:0]       state;
  logic [CNT_W-1:0] count;
  logic [IDX_W-1:0] head;
  logic [CNT_W-1:0] idx;
  logic [CNT_W-1:0] idx_inc;
  cmd_t             cmd_r;
  value_t           val_r;
  status_t          res_status;
  logic             res_use_ram;
  logic             res_last;
  logic             res_free;

  logic [CNT_W-1:0] offset;
  logic [CNT_W:0]   sum;
  logic [IDX_W-1:0] slot;

  logic             ram_we;
  value_t           ram_wdata;
  logic             ram_re;
  logic [IDX_W-1:0] ram_raddr;
  value_t           ram_rdata;

  logic             enq_ok;
  logic             cnt_full;
  logic             cnt_empty;

  assign idx_inc   = idx + CNT_W'(1);
  assign cnt_full  = (count == CNT_W'(DEPTH));
  assign cnt_empty = (count == '0);
  assign enq_ok    = (cmd_r == CMD_ENQUEUE) && (val_r != '0) && !cnt_full;
  assign res_free  = !res_valid || !res_stall;
  assign cmd_stall = (state != S_IDLE);

  // Shared address unit: store slot of (head + offset) modulo DEPTH.
  always_comb begin
    case (state)
      S_CMD:   offset = count;
      S_DHEAD: offset = CNT_W'(1);
      S_SHRD:  offset = idx_inc;
      default: offset = idx;
    endcase
    sum = (CNT_W+1)'(head) + (CNT_W+1)'(offset);
    if (sum >= (CNT_W+1)'(DEPTH)) begin
      slot = IDX_W'(sum - (CNT_W+1)'(DEPTH));
    end else begin
      slot = IDX_W'(sum);
    end
  end

  assign ram_we    = ((state == S_CMD) && enq_ok) || (state == S_SHWR);
  assign ram_wdata = (state == S_SHWR) ? ram_rdata : val_r;
  assign ram_raddr = (state == S_CMD) ? head : slot;
  assign ram_re    = ((state == S_CMD) && (cmd_r == CMD_DEQUEUE) && !cnt_empty)
                   || ((state == S_SRD) && (idx != count))
                   || ((state == S_SHRD) && (idx_inc != count))
                   || (state == S_IRD);

  fqd_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      head      <= '0;
      res_valid <= 1'b0;
    end else begin
      // Outside the emit state the output register only drains.
      if (!res_stall && (state != S_EMIT)) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            cmd_r <= command;
            val_r <= item_value;
            state <= S_CMD;
          end
        end
        S_CMD: begin
          res_use_ram <= 1'b0;
          res_last    <= 1'b1;
          res_status  <= ST_OK;
          idx         <= '0;
          state       <= S_EMIT;
          case (cmd_r)
            CMD_ENQUEUE: begin
              if (val_r == '0) begin
                res_status <= ST_ZERO;
              end else if (cnt_full) begin
                res_status <= ST_FULL;
              end else begin
                count <= count + CNT_W'(1);
              end
            end
            CMD_DEQUEUE: begin
              if (cnt_empty) begin
                res_status <= ST_EMPTY;
              end else begin
                res_use_ram <= 1'b1;
                state       <= S_DHEAD;
              end
            end
            CMD_DELETE: begin
              if (val_r == '0) begin
                res_status <= ST_ZERO;
              end else begin
                state <= S_SRD;
              end
            end
            CMD_ITERATE: begin
              if (!cnt_empty) begin
                state <= S_IRD;
              end
            end
            default: begin
            end
          endcase
        end
        S_DHEAD: begin
          head  <= slot;
          count <= count - CNT_W'(1);
          state <= S_EMIT;
        end
        S_SRD: begin
          if (idx == count) begin
            res_status <= ST_NOTFOUND;
            state      <= S_EMIT;
          end else begin
            state <= S_SCMP;
          end
        end
        S_SCMP: begin
          if (ram_rdata == val_r) begin
            state <= S_SHRD;
          end else begin
            idx   <= idx_inc;
            state <= S_SRD;
          end
        end
        S_SHRD: begin
          // Close the gap once the tail entry has moved up.
          if (idx_inc == count) begin
            count <= count - CNT_W'(1);
            state <= S_EMIT;
          end else begin
            state <= S_SHWR;
          end
        end
        S_SHWR: begin
          idx   <= idx_inc;
          state <= S_SHRD;
        end
        S_IRD: begin
          res_use_ram <= 1'b1;
          res_last    <= (idx_inc == count);
          res_status  <= ST_OK;
          state       <= S_EMIT;
        end
        S_EMIT: begin
          if (res_free) begin
            res_valid <= 1'b1;
            status    <= res_status;
            value_out <= res_use_ram ? ram_rdata : '0;
            count_out <= COUNT_OUT_W'(count);
            last      <= res_last;
            if (res_last) begin
              state <= S_IDLE;
            end else begin
              idx   <= idx_inc;
              state <= S_IRD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$stable(count)) |->
      ((count == $past(count) + CNT_W'(1)) || (count == $past(count) - CNT_W'(1))))
    else $error("entry count moved by more than one");

  a_head_on_dequeue: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$stable(head)) |-> (count == $past(count) - CNT_W'(1)))
    else $error("head moved without an entry leaving");

  a_enqueue_room: assert property (@(posedge clk) disable iff (rst)
    (ram_we && (state == S_CMD)) |-> (count < CNT_W'(DEPTH)))
    else $error("enqueue write into a full store");

  a_single_pending: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && res_valid && res_stall) |=> (state == S_EMIT))
    else $error("result dropped while output stalled");

endmodule

@@ verif/fifo_queue_with_delete_test.sv @@
`timescale 1ns / 1ps

module fifo_queue_with_delete_test;
  import fqd_pkg::*;

  localparam int          DEPTH           = DEPTH_DEFAULT;
  localparam int          RANDOM_ITEMS    = 350;
  localparam int          IDLE_LIMIT      = 3000;
  localparam int          SETTLE_CYCLES   = 60;
  localparam cmd_t        CMD_SPARE_FIRST = CMD_ITERATE + 3'd1;
  localparam cmd_t        CMD_SPARE_LAST  = '1;
  localparam value_t      HANDLE_MAX      = '1;
  localparam value_t      HANDLE_TOP_BIT  = {1'b1, {(VALUE_W-1){1'b0}}};

  typedef struct packed {
    cmd_t   cmd;
    value_t handle;
  } queue_command_t;

  typedef struct packed {
    status_t    status;
    value_t     value;
    count_out_t count;
    logic       last;
  } queue_result_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cmd_valid = 1'b0;
  logic       cmd_stall;
  cmd_t       command = CMD_ENQUEUE;
  value_t     item_value = '0;
  logic       res_valid;
  logic       res_stall = 1'b0;
  status_t    status;
  value_t     value_out;
  count_out_t count_out;
  logic       last;

  queue_command_t queued_commands[$];
  queue_result_t  due_results[$];

  // mirror of the queue contents
  value_t      mirror_store[DEPTH];
  int unsigned mirror_count = 0;
  int unsigned mirror_head  = 0;

  int          mismatch_count = 0;
  int unsigned cmd_wait  = 0;
  int unsigned res_wait  = 0;
  bit          cmd_quiet = 1'b0;
  bit          res_quiet = 1'b0;
  int unsigned idle_cycles = 0;

  fifo_queue_with_delete #(.DEPTH(DEPTH)) i_dut (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_stall  (cmd_stall),
    .command    (command),
    .item_value (item_value),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .status     (status),
    .value_out  (value_out),
    .count_out  (count_out),
    .last       (last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int unsigned slot_at(int unsigned offset);
    return (mirror_head + offset) % DEPTH;
  endfunction

  function automatic void post_result(status_t st, value_t val, logic is_last);
    queue_result_t r;
    r.status = st;
    r.value  = val;
    r.count  = count_out_t'(mirror_count);
    r.last   = is_last;
    due_results.push_back(r);
  endfunction

  function automatic void apply_queue_command(cmd_t cmd, value_t val);
    int unsigned pos;
    int unsigned i;
    value_t      head_val;
    case (cmd)
      CMD_ENQUEUE: begin
        if (val == '0) begin
          post_result(ST_ZERO, '0, 1'b1);
        end else if (mirror_count >= DEPTH) begin
          post_result(ST_FULL, '0, 1'b1);
        end else begin
          mirror_store[slot_at(mirror_count)] = val;
          mirror_count++;
          post_result(ST_OK, '0, 1'b1);
        end
      end
      CMD_DEQUEUE: begin
        if (mirror_count == 0) begin
          post_result(ST_EMPTY, '0, 1'b1);
        end else begin
          head_val    = mirror_store[slot_at(0)];
          mirror_head = slot_at(1);
          mirror_count--;
          post_result(ST_OK, head_val, 1'b1);
        end
      end
      CMD_DELETE: begin
        if (val == '0) begin
          post_result(ST_ZERO, '0, 1'b1);
        end else begin
          pos = mirror_count;
          for (i = 0; i < mirror_count; i++) begin
            if (pos == mirror_count && mirror_store[slot_at(i)] == val) pos = i;
          end
          if (pos == mirror_count) begin
            post_result(ST_NOTFOUND, '0, 1'b1);
          end else begin
            // close the gap, later entries move up one place
            for (i = pos; i + 1 < mirror_count; i++)
              mirror_store[slot_at(i)] = mirror_store[slot_at(i + 1)];
            mirror_count--;
            post_result(ST_OK, '0, 1'b1);
          end
        end
      end
      CMD_ITERATE: begin
        if (mirror_count == 0) begin
          post_result(ST_OK, '0, 1'b1);
        end else begin
          for (i = 0; i < mirror_count; i++)
            post_result(ST_OK, mirror_store[slot_at(i)], i + 1 == mirror_count);
        end
      end
      CMD_LENGTH: post_result(ST_OK, '0, 1'b1);
      default:    post_result(ST_OK, '0, 1'b1);
    endcase
  endfunction

  function automatic int unsigned draw_wait(bit quiet);
    return quiet ? 0 : $urandom_range(0, 15);
  endfunction

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  function automatic void add_command(cmd_t cmd, value_t handle);
    queue_command_t c;
    c.cmd    = cmd;
    c.handle = handle;
    queued_commands.push_back(c);
  endfunction

  // small pool so that deletes hit and duplicates occur
  function automatic value_t pick_handle();
    return value_t'($urandom_range(1, 20));
  endfunction

  // command driver
  always @(posedge clk) begin : command_driver
    bit presenting;
    queue_command_t next_cmd;
    if (!rst) begin
      presenting = cmd_valid;
      if (cmd_valid && !cmd_stall) begin
        apply_queue_command(command, item_value);
        if ($urandom_range(0, 39) == 0) cmd_quiet = !cmd_quiet;
        cmd_wait   = draw_wait(cmd_quiet);
        presenting = 1'b0;
      end
      if (!presenting) begin
        if (cmd_wait > 0) begin
          cmd_wait--;
          cmd_valid <= 1'b0;
        end else if (queued_commands.size() > 0) begin
          next_cmd    = queued_commands.pop_front();
          cmd_valid  <= 1'b1;
          command    <= next_cmd.cmd;
          item_value <= next_cmd.handle;
        end else begin
          cmd_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin : result_monitor
    queue_result_t due;
    if (!rst) begin
      if (res_valid && !res_stall) begin
        if (due_results.size() == 0) begin
          $error("result with nothing outstanding: status %0d value 0x%0h count %0d last %0b",
                 status, value_out, count_out, last);
          mismatch_count++;
        end else begin
          due = due_results.pop_front();
          compare_field("status", 32'(due.status), 32'(status));
          compare_field("value_out", due.value, value_out);
          compare_field("count_out", 32'(due.count), 32'(count_out));
          compare_field("last", 32'(due.last), 32'(last));
        end
        if ($urandom_range(0, 39) == 0) res_quiet = !res_quiet;
        res_wait = draw_wait(res_quiet);
      end else if (res_wait > 0) begin
        res_wait--;
      end
      res_stall <= (res_wait > 0);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (cmd_valid && !cmd_stall) || (res_valid && !res_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("fifo_queue_with_delete_test: errors");
      $finish;
    end
  end

  initial begin
    int unsigned planned;
    int unsigned burst_len;
    int unsigned k;
    value_t      wide_handle;

    // empty queue corners
    add_command(CMD_LENGTH, '0);
    add_command(CMD_DEQUEUE, HANDLE_MAX);
    add_command(CMD_ITERATE, '0);
    add_command(CMD_DELETE, 32'd5);
    add_command(CMD_DELETE, '0);
    add_command(CMD_ENQUEUE, '0);
    // extremes, delete from the middle and at the tail
    add_command(CMD_ENQUEUE, HANDLE_MAX);
    add_command(CMD_ENQUEUE, 32'd1);
    add_command(CMD_ENQUEUE, HANDLE_TOP_BIT);
    add_command(CMD_ITERATE, HANDLE_MAX);
    add_command(CMD_DELETE, 32'd1);
    add_command(CMD_DELETE, HANDLE_TOP_BIT);
    add_command(CMD_ENQUEUE, 32'd7);
    add_command(CMD_ITERATE, '0);
    add_command(CMD_DELETE, 32'd9);
    add_command(CMD_SPARE_FIRST, HANDLE_MAX);
    add_command(CMD_SPARE_FIRST + 3'd1, 32'd3);
    add_command(CMD_SPARE_LAST, '0);
    add_command(CMD_LENGTH, HANDLE_MAX);
    add_command(CMD_DEQUEUE, '0);
    add_command(CMD_DEQUEUE, '0);
    add_command(CMD_DEQUEUE, '0);

    wide_handle = HANDLE_MAX;
    planned = 0;
    while (planned < RANDOM_ITEMS) begin
      case ($urandom_range(0, 5))
        0, 1: begin
          // fill, often up to full and beyond
          burst_len = $urandom_range(8, 20);
          for (k = 0; k < burst_len; k++) begin
            if ($urandom_range(0, 7) == 0) begin
              wide_handle = value_t'($urandom);
              add_command(CMD_ENQUEUE, wide_handle);
            end else begin
              add_command(CMD_ENQUEUE, pick_handle());
            end
          end
          if ($urandom_range(0, 1) == 0) add_command(CMD_ITERATE, value_t'($urandom));
          planned += burst_len + 1;
        end
        2, 3: begin
          // drain by dequeue and delete
          burst_len = $urandom_range(4, 18);
          for (k = 0; k < burst_len; k++) begin
            if ($urandom_range(0, 1) == 0) add_command(CMD_DEQUEUE, value_t'($urandom));
            else if ($urandom_range(0, 5) == 0) add_command(CMD_DELETE, wide_handle);
            else add_command(CMD_DELETE, pick_handle());
          end
          planned += burst_len;
        end
        4: begin
          burst_len = $urandom_range(10, 20);
          for (k = 0; k < burst_len; k++) begin
            case ($urandom_range(0, 9))
              0, 1, 2: add_command(CMD_ENQUEUE, pick_handle());
              3:       add_command(CMD_DEQUEUE, value_t'($urandom));
              4, 5:    add_command(CMD_DELETE, pick_handle());
              6:       add_command(CMD_LENGTH, value_t'($urandom));
              7:       add_command(CMD_ITERATE, value_t'($urandom));
              8:       add_command(CMD_ENQUEUE, '0);
              default: add_command(CMD_DELETE, '0);
            endcase
          end
          planned += burst_len;
        end
        default: begin
          // noise: any command code, any handle
          burst_len = $urandom_range(3, 6);
          for (k = 0; k < burst_len; k++)
            add_command(cmd_t'($urandom_range(0, 7)),
                        $urandom_range(0, 3) == 0 ? '0 : value_t'($urandom));
          planned += burst_len;
        end
      endcase
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk);
    while (queued_commands.size() != 0 || cmd_valid || due_results.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);

    if (mismatch_count == 0 && due_results.size() == 0) begin
      $display("fifo_queue_with_delete_test: clean");
    end else begin
      $display("fifo_queue_with_delete_test: errors");
    end
    $finish;
  end

endmodule
